@@ sv/srbp_pkg.sv @@
// Shared types, codes and widths for the segregated buffer pool unit.
package srbp_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 80;
    localparam int USE_W     = 7;
    localparam int POOL_MAX  = 64;
    localparam int OFF_W     = 6;
    localparam int SLOT_IN_W = 8;
    localparam int REF_OUT_W = 8;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_ADDREF  = 2'd2,
        MODE_CLEAR   = 2'd3
    } srbp_mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_SLOT  = 2'd2,
        ST_SATURATED = 2'd3
    } srbp_status_t;

    typedef enum logic [1:0] {
        POOL_BASIC    = 2'd0,
        POOL_DATAGRAM = 2'd1,
        POOL_SNIP     = 2'd2,
        POOL_STREAM   = 2'd3
    } srbp_pool_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } srbp_cmd_t;

endpackage

@@ sv/srbp_ctrl.sv @@
// Request sequencer: accept, execute and result register handshake.
module srbp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output srbp_pkg::srbp_cmd_t cmd
);
    import srbp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/srbp_datapath.sv @@
// Slot flags, reference count memory, pool counters and result register.
module srbp_datapath #(
    parameter int BASIC_SLOTS    = 16,
    parameter int DATAGRAM_SLOTS = 8,
    parameter int SNIP_SLOTS     = 4,
    parameter int STREAM_SLOTS   = 2,
    parameter int COUNT_BITS     = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  srbp_pkg::srbp_cmd_t          cmd,
    input  logic [srbp_pkg::IN_W-1:0]    s_tdata,
    output logic [srbp_pkg::OUT_W-1:0]   m_tdata
);
    import srbp_pkg::*;

    localparam int TOTAL  = BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS + STREAM_SLOTS;
    localparam int SLOT_W = $clog2(TOTAL);
    localparam int B1     = BASIC_SLOTS;
    localparam int B2     = B1 + DATAGRAM_SLOTS;
    localparam int B3     = B2 + SNIP_SLOTS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    srbp_mode_t              mode_reg;
    logic [1:0]              pool_reg;
    logic [SLOT_IN_W-1:0]    slot_reg;
    logic [COUNT_BITS-1:0]   rd_reg;
    logic [COUNT_BITS-1:0]   refs_mem [TOTAL];

    logic [TOTAL-1:0]        busy_reg, busy_next;
    logic [3:0][USE_W-1:0]   in_use_reg, in_use_next;
    logic [3:0][USE_W-1:0]   peak_reg, peak_next;
    logic [OUT_W-1:0]        out_reg;

    logic [3:0][POOL_MAX-1:0] free_vec;
    logic [POOL_MAX-1:0]      sel_free;
    logic [OFF_W-1:0]         off;
    logic                     found;
    logic [8:0]               base9;
    logic [8:0]               alloc9;
    logic [SLOT_W-1:0]        slot_idx;
    logic                     in_range;
    logic                     slot_ok;
    logic [1:0]               rel_pool;
    logic [USE_W-1:0]         use_inc;

    srbp_status_t             status;
    logic [SLOT_IN_W-1:0]     idx_out;
    logic [COUNT_BITS-1:0]    cnt;
    logic [15:0]              cnt16;
    logic [REF_OUT_W-1:0]     ref_out;
    logic                     mem_we;
    logic [SLOT_W-1:0]        mem_wa;
    logic [COUNT_BITS-1:0]    mem_wd;

    for (genvar i = 0; i < POOL_MAX; i++) begin : g_free
        if (i < BASIC_SLOTS) begin : g_b
            assign free_vec[0][i] = ~busy_reg[i];
        end else begin : g_bz
            assign free_vec[0][i] = 1'b0;
        end
        if (i < DATAGRAM_SLOTS) begin : g_d
            assign free_vec[1][i] = ~busy_reg[B1 + i];
        end else begin : g_dz
            assign free_vec[1][i] = 1'b0;
        end
        if (i < SNIP_SLOTS) begin : g_s
            assign free_vec[2][i] = ~busy_reg[B2 + i];
        end else begin : g_sz
            assign free_vec[2][i] = 1'b0;
        end
        if (i < STREAM_SLOTS) begin : g_t
            assign free_vec[3][i] = ~busy_reg[B3 + i];
        end else begin : g_tz
            assign free_vec[3][i] = 1'b0;
        end
    end

    assign sel_free = free_vec[pool_reg];
    assign found    = |sel_free;

    always_comb begin
        off = '0;
        for (int i = POOL_MAX - 1; i >= 0; i--) begin
            if (sel_free[i]) begin
                off = OFF_W'(i);
            end
        end
    end

    always_comb begin
        case (pool_reg)
            POOL_BASIC:    base9 = 9'd0;
            POOL_DATAGRAM: base9 = 9'(B1);
            POOL_SNIP:     base9 = 9'(B2);
            default:       base9 = 9'(B3);
        endcase
    end

    assign alloc9   = base9 + {3'b000, off};
    assign slot_idx = slot_reg[SLOT_W-1:0];
    assign in_range = ({1'b0, slot_reg} < 9'(TOTAL));
    assign slot_ok  = in_range && busy_reg[slot_idx];
    assign use_inc  = in_use_reg[pool_reg] + USE_W'(1);

    always_comb begin
        if ({1'b0, slot_reg} < 9'(B1)) begin
            rel_pool = POOL_BASIC;
        end else if ({1'b0, slot_reg} < 9'(B2)) begin
            rel_pool = POOL_DATAGRAM;
        end else if ({1'b0, slot_reg} < 9'(B3)) begin
            rel_pool = POOL_SNIP;
        end else begin
            rel_pool = POOL_STREAM;
        end
    end

    always_comb begin
        status      = ST_OK;
        idx_out     = '0;
        cnt         = '0;
        busy_next   = busy_reg;
        in_use_next = in_use_reg;
        peak_next   = peak_reg;
        mem_we      = 1'b0;
        mem_wa      = slot_idx;
        mem_wd      = rd_reg;
        case (mode_reg)
            MODE_ALLOC: begin
                if (found) begin
                    busy_next[alloc9[SLOT_W-1:0]] = 1'b1;
                    in_use_next[pool_reg]         = use_inc;
                    if (use_inc > peak_reg[pool_reg]) begin
                        peak_next[pool_reg] = use_inc;
                    end
                    mem_we  = 1'b1;
                    mem_wa  = alloc9[SLOT_W-1:0];
                    mem_wd  = COUNT_BITS'(1);
                    idx_out = alloc9[SLOT_IN_W-1:0];
                    cnt     = COUNT_BITS'(1);
                end else begin
                    status = ST_EXHAUSTED;
                end
            end
            MODE_RELEASE: begin
                idx_out = slot_reg;
                if (!slot_ok) begin
                    status = ST_BAD_SLOT;
                end else begin
                    cnt = (rd_reg != '0) ? rd_reg - COUNT_BITS'(1) : rd_reg;
                    mem_we = 1'b1;
                    mem_wd = cnt;
                    if (cnt == '0) begin
                        busy_next[slot_idx] = 1'b0;
                        if (in_use_reg[rel_pool] != '0) begin
                            in_use_next[rel_pool] = in_use_reg[rel_pool] - USE_W'(1);
                        end
                    end
                end
            end
            MODE_ADDREF: begin
                idx_out = slot_reg;
                if (!slot_ok) begin
                    status = ST_BAD_SLOT;
                end else if (rd_reg == COUNT_MAX) begin
                    status = ST_SATURATED;
                    cnt    = rd_reg;
                end else begin
                    cnt    = rd_reg + COUNT_BITS'(1);
                    mem_we = 1'b1;
                    mem_wd = cnt;
                end
            end
            MODE_CLEAR: begin
                peak_next = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign cnt16   = 16'(cnt);
    assign ref_out = (cnt16 > 16'd255) ? 8'hFF : cnt16[REF_OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= srbp_mode_t'(s_tdata[1:0]);
            pool_reg <= s_tdata[3:2];
            slot_reg <= s_tdata[11:4];
            rd_reg   <= refs_mem[s_tdata[4 +: SLOT_W]];
        end
        if (cmd.commit && mem_we) begin
            refs_mem[mem_wa] <= mem_wd;
        end
        if (cmd.commit) begin
            out_reg <= {6'd0,
                        peak_next[3], peak_next[2], peak_next[1], peak_next[0],
                        in_use_next[3], in_use_next[2], in_use_next[1], in_use_next[0],
                        ref_out, idx_out, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= '0;
            in_use_reg <= '0;
            peak_reg   <= '0;
        end else if (cmd.commit) begin
            busy_reg   <= busy_next;
            in_use_reg <= in_use_next;
            peak_reg   <= peak_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

@@ sv/segregated_refcounted_buffer_pool_unit.sv @@
// Top level of the four-pool reference-counted buffer slot manager.
// In the transfer cycle, taken in the idle state, the slot's reference count is read from
// the count memory into a register; in the execute state the lowest-free-slot search over
// the pool's busy flags runs and the count is written back. A new request is taken only
// once the execute state has finished and the block is back in the idle state.
// The result sits in an output register; while an earlier result waits there, the
// execute cycle holds until it is taken. Busy flags clear at reset, so the block
// needs no clearing pass and takes requests right after reset.
module segregated_refcounted_buffer_pool_unit #(
    parameter int BASIC_SLOTS    = 16,
    parameter int DATAGRAM_SLOTS = 8,
    parameter int SNIP_SLOTS     = 4,
    parameter int STREAM_SLOTS   = 2,
    parameter int COUNT_BITS     = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // mode[1:0], pool[3:2], slot[11:4], zero[15:12]
    input  logic [srbp_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[1:0], slot_index[9:2], ref_count[17:10], basic_in_use[24:18],
    // datagram_in_use[31:25], snip_in_use[38:32], stream_in_use[45:39],
    // basic_peak[52:46], datagram_peak[59:53], snip_peak[66:60],
    // stream_peak[73:67], zero[79:74]
    output logic [srbp_pkg::OUT_W-1:0] m_tdata
);
    import srbp_pkg::*;

    srbp_cmd_t cmd;

    srbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    srbp_datapath #(
        .BASIC_SLOTS    (BASIC_SLOTS),
        .DATAGRAM_SLOTS (DATAGRAM_SLOTS),
        .SNIP_SLOTS     (SNIP_SLOTS),
        .STREAM_SLOTS   (STREAM_SLOTS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

@@ sv/srbp_checker.sv @@
// Port-level checks for the buffer pool unit, bound to the top level.
module srbp_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [srbp_pkg::IN_W-1:0]  s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [srbp_pkg::OUT_W-1:0] m_tdata
);
    import srbp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken during execute cycle");

    a_exhausted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_EXHAUSTED) |->
            (m_tdata[9:2] == 8'd0) && (m_tdata[17:10] == 8'd0))
        else $error("exhausted result carries a slot");

    a_bad_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_BAD_SLOT) |-> (m_tdata[17:10] == 8'd0))
        else $error("bad slot result carries a count");

    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_SATURATED) |-> (m_tdata[17:10] != 8'd0))
        else $error("saturated result with zero count");

endmodule

bind segregated_refcounted_buffer_pool_unit srbp_checker u_srbp_checker (.*);

@@ verif/srbp_reply_checker.sv @@
// Reply checker for the buffer pool unit: shadows the slot state and compares every reply.
module srbp_reply_checker #(
    parameter int BASIC_SLOTS    = 16,
    parameter int DATAGRAM_SLOTS = 8,
    parameter int SNIP_SLOTS     = 4,
    parameter int STREAM_SLOTS   = 2,
    parameter int COUNT_BITS     = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [srbp_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [srbp_pkg::OUT_W-1:0] m_tdata,
    output int                         errors,
    output int                         outstanding
);
    import srbp_pkg::*;

    localparam int TOTAL_SLOTS = BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS + STREAM_SLOTS;
    localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;

    typedef struct packed {
        srbp_status_t               status;
        logic [7:0]                 slot_index;
        logic [7:0]                 ref_count;
        logic [3:0][USE_W-1:0]      in_use;
        logic [3:0][USE_W-1:0]      peak;
    } slot_reply_t;

    slot_reply_t          replies_due[$];
    bit                   slot_taken [TOTAL_SLOTS];
    int                   slot_refs  [TOTAL_SLOTS];
    logic [USE_W-1:0]     pool_in_use[4];
    logic [USE_W-1:0]     pool_peak  [4];
    int                   pool_lo    [4];
    int                   pool_len   [4];
    int                   reply_no;

    initial begin
        errors      = 0;
        outstanding = 0;
        reply_no    = 0;
        pool_len[0] = BASIC_SLOTS;
        pool_len[1] = DATAGRAM_SLOTS;
        pool_len[2] = SNIP_SLOTS;
        pool_len[3] = STREAM_SLOTS;
        pool_lo[0]  = 0;
        pool_lo[1]  = BASIC_SLOTS;
        pool_lo[2]  = BASIC_SLOTS + DATAGRAM_SLOTS;
        pool_lo[3]  = BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS;
    end

    task automatic flag(string what);
        $display("reply %0d: %s", reply_no, what);
        errors++;
    endtask

    task automatic model_request(srbp_mode_t mode, srbp_pool_t pool, logic [7:0] slot);
        slot_reply_t r;
        int          s;
        int          p;
        int          cnt;
        bit          found;
        r     = '0;
        cnt   = 0;
        found = 1'b0;
        case (mode)
            MODE_ALLOC: begin
                for (s = pool_lo[pool]; s < pool_lo[pool] + pool_len[pool]; s++) begin
                    if (!found && !slot_taken[s]) begin
                        slot_taken[s]     = 1'b1;
                        slot_refs[s]      = 1;
                        pool_in_use[pool] = pool_in_use[pool] + 1'b1;
                        if (pool_in_use[pool] > pool_peak[pool])
                            pool_peak[pool] = pool_in_use[pool];
                        r.slot_index = s[7:0];
                        cnt          = 1;
                        found        = 1'b1;
                    end
                end
                if (!found)
                    r.status = ST_EXHAUSTED;
            end
            MODE_RELEASE, MODE_ADDREF: begin
                r.slot_index = slot;
                if (int'(slot) >= TOTAL_SLOTS) begin
                    r.status = ST_BAD_SLOT;
                end else if (!slot_taken[slot]) begin
                    r.status = ST_BAD_SLOT;
                end else if (mode == MODE_RELEASE) begin
                    p = 0;
                    for (s = 1; s < 4; s++)
                        if (int'(slot) >= pool_lo[s])
                            p = s;
                    if (slot_refs[slot] > 0)
                        slot_refs[slot]--;
                    if (slot_refs[slot] == 0) begin
                        slot_taken[slot] = 1'b0;
                        if (pool_in_use[p] > 0)
                            pool_in_use[p] = pool_in_use[p] - 1'b1;
                    end
                    cnt = slot_refs[slot];
                end else begin
                    if (slot_refs[slot] >= COUNT_MAX)
                        r.status = ST_SATURATED;
                    else
                        slot_refs[slot]++;
                    cnt = slot_refs[slot];
                end
            end
            default: begin
                for (s = 0; s < 4; s++)
                    pool_peak[s] = '0;
            end
        endcase
        r.ref_count = (cnt > 255) ? 8'd255 : cnt[7:0];
        for (s = 0; s < 4; s++) begin
            r.in_use[s] = pool_in_use[s];
            r.peak[s]   = pool_peak[s];
        end
        replies_due.push_back(r);
    endtask

    always @(posedge aclk) begin
        slot_reply_t got;
        slot_reply_t want;
        int          i;
        if (!aresetn) begin
            replies_due.delete();
            for (i = 0; i < TOTAL_SLOTS; i++) begin
                slot_taken[i] = 1'b0;
                slot_refs[i]  = 0;
            end
            for (i = 0; i < 4; i++) begin
                pool_in_use[i] = '0;
                pool_peak[i]   = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                got.status     = srbp_status_t'(m_tdata[1:0]);
                got.slot_index = m_tdata[9:2];
                got.ref_count  = m_tdata[17:10];
                for (i = 0; i < 4; i++) begin
                    got.in_use[i] = m_tdata[18 + USE_W * i +: USE_W];
                    got.peak[i]   = m_tdata[46 + USE_W * i +: USE_W];
                end
                if (replies_due.size() == 0) begin
                    flag("transfer with no request pending");
                end else begin
                    want = replies_due.pop_front();
                    if (got.status != want.status)
                        flag($sformatf("status got %0d expected %0d",
                                       int'(got.status), int'(want.status)));
                    if (got.slot_index != want.slot_index)
                        flag($sformatf("slot_index got %0d expected %0d",
                                       got.slot_index, want.slot_index));
                    if (got.ref_count != want.ref_count)
                        flag($sformatf("ref_count got %0d expected %0d",
                                       got.ref_count, want.ref_count));
                    for (i = 0; i < 4; i++) begin
                        if (got.in_use[i] != want.in_use[i])
                            flag($sformatf("in_use of pool %0d got %0d expected %0d",
                                           i, got.in_use[i], want.in_use[i]));
                        if (got.peak[i] != want.peak[i])
                            flag($sformatf("peak of pool %0d got %0d expected %0d",
                                           i, got.peak[i], want.peak[i]));
                    end
                end
                reply_no++;
            end
            if (s_tvalid && s_tready)
                model_request(srbp_mode_t'(s_tdata[1:0]), srbp_pool_t'(s_tdata[3:2]),
                              s_tdata[11:4]);
        end
        outstanding <= replies_due.size();
    end

endmodule

@@ verif/tb_segregated_refcounted_buffer_pool_unit.sv @@
// Testbench top for the buffer pool unit: directed and random requests, random stalls, verdict.
module tb_segregated_refcounted_buffer_pool_unit;
    import srbp_pkg::*;

    localparam int BASIC_SLOTS    = 16;
    localparam int DATAGRAM_SLOTS = 8;
    localparam int SNIP_SLOTS     = 4;
    localparam int STREAM_SLOTS   = 2;
    localparam int COUNT_BITS     = 8;
    localparam int ITEM_TARGET    = 650;
    localparam int CALM_FROM      = 570;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tready = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [OUT_W-1:0]  m_tdata;

    int errors;
    int outstanding;
    int sent       = 0;
    int stall_left = 0;
    bit idle_on    = 1'b1;
    int pool_lo [4];
    int pool_len[4];

    segregated_refcounted_buffer_pool_unit #(
        .BASIC_SLOTS   (BASIC_SLOTS),
        .DATAGRAM_SLOTS(DATAGRAM_SLOTS),
        .SNIP_SLOTS    (SNIP_SLOTS),
        .STREAM_SLOTS  (STREAM_SLOTS),
        .COUNT_BITS    (COUNT_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    srbp_reply_checker #(
        .BASIC_SLOTS   (BASIC_SLOTS),
        .DATAGRAM_SLOTS(DATAGRAM_SLOTS),
        .SNIP_SLOTS    (SNIP_SLOTS),
        .STREAM_SLOTS  (STREAM_SLOTS),
        .COUNT_BITS    (COUNT_BITS)
    ) replies (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .outstanding(outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (idle_on && stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= int'($urandom_range(1, 18)) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_request(srbp_mode_t mode, srbp_pool_t pool, logic [7:0] slot);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, slot, pool, mode};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic random_request();
        srbp_mode_t mode;
        srbp_pool_t pool;
        logic [7:0] slot;
        int         pick;
        int         p;
        pick = $urandom_range(0, 99);
        pool = srbp_pool_t'($urandom_range(0, 3));
        slot = 8'($urandom_range(0, 255));
        if (pick < 40)
            mode = MODE_ALLOC;
        else if (pick < 75)
            mode = MODE_RELEASE;
        else if (pick < 95)
            mode = MODE_ADDREF;
        else
            mode = MODE_CLEAR;
        if ((mode == MODE_RELEASE || mode == MODE_ADDREF) && $urandom_range(0, 99) < 85) begin
            p    = $urandom_range(0, 3);
            slot = 8'(pool_lo[p] + int'($urandom_range(0, pool_len[p] - 1)));
        end
        push_request(mode, pool, slot);
    endtask

    initial begin
        int p;
        int i;
        int k;
        pool_len[0] = BASIC_SLOTS;
        pool_len[1] = DATAGRAM_SLOTS;
        pool_len[2] = SNIP_SLOTS;
        pool_len[3] = STREAM_SLOTS;
        pool_lo[0]  = 0;
        pool_lo[1]  = BASIC_SLOTS;
        pool_lo[2]  = BASIC_SLOTS + DATAGRAM_SLOTS;
        pool_lo[3]  = BASIC_SLOTS + DATAGRAM_SLOTS + SNIP_SLOTS;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_request(MODE_ALLOC,   POOL_BASIC,    8'd0);
        push_request(MODE_ALLOC,   POOL_DATAGRAM, 8'd0);
        push_request(MODE_ALLOC,   POOL_SNIP,     8'd0);
        push_request(MODE_ALLOC,   POOL_STREAM,   8'd0);
        push_request(MODE_ALLOC,   POOL_STREAM,   8'd0);
        push_request(MODE_ALLOC,   POOL_STREAM,   8'd0);
        push_request(MODE_ADDREF,  POOL_BASIC,    8'd0);
        push_request(MODE_RELEASE, POOL_BASIC,    8'd0);
        push_request(MODE_RELEASE, POOL_BASIC,    8'd0);
        push_request(MODE_RELEASE, POOL_BASIC,    8'd0);
        push_request(MODE_ADDREF,  POOL_BASIC,    8'd0);
        push_request(MODE_RELEASE, POOL_BASIC,    8'd30);
        push_request(MODE_ADDREF,  POOL_STREAM,   8'd255);
        push_request(MODE_RELEASE, POOL_STREAM,   8'd128);
        push_request(MODE_CLEAR,   POOL_BASIC,    8'd0);
        push_request(MODE_ALLOC,   POOL_SNIP,     8'd255);
        push_request(MODE_RELEASE, POOL_SNIP,     8'd25);
        push_request(MODE_ALLOC,   POOL_BASIC,    8'd255);
        push_request(MODE_CLEAR,   POOL_STREAM,   8'd255);
        push_request(MODE_ADDREF,  POOL_DATAGRAM, 8'd29);

        // drive one stream slot into count saturation
        for (i = 0; i < 256; i++)
            push_request(MODE_ADDREF, POOL_STREAM, 8'd29);

        while (sent < ITEM_TARGET) begin
            if (sent >= CALM_FROM)
                idle_on <= 1'b0;
            else if (sent % 50 < 2)
                idle_on <= ($urandom_range(0, 3) != 0);
            k = $urandom_range(0, 9);
            if (k < 2) begin
                // fill a pool past its end, then drain it
                p = $urandom_range(0, 3);
                for (i = 0; i <= pool_len[p]; i++)
                    push_request(MODE_ALLOC, srbp_pool_t'(p), 8'($urandom_range(0, 255)));
                for (i = 0; i < 2 * pool_len[p]; i++)
                    push_request(MODE_RELEASE, srbp_pool_t'($urandom_range(0, 3)),
                                 8'(pool_lo[p] + i % pool_len[p]));
            end else begin
                random_request();
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
